FILE: rtl/grd_pkg.sv
// Shared types and constants for the grid potential gradient block.
// No dependencies; every other file of the block imports this package.
package grd_pkg;

   localparam int LINE_LEN_DEF    = 32;
   localparam int MAX_LINES_DEF   = 1024;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int SLOT_COUNT = 3;
   localparam int SLOT_W     = 2;
   localparam int MIN_DIM    = 3;

   localparam int FIELD_W    = 32;
   localparam int INV_W      = 16;
   localparam int LEN_REG_W  = 6;
   localparam int CNT_REG_W  = 11;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam int SHIFT_ONE  = 12;
   localparam int SHIFT_HALF = 13;

   localparam logic [INV_W-1:0]     INV_SPACING_RST = 16'd4096;
   localparam logic [LEN_REG_W-1:0] LINE_LENGTH_RST = 6'd32;
   localparam logic [CNT_REG_W-1:0] LINE_COUNT_RST  = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_SPACING = 2'd0,
      CSR_LINE_LENGTH = 2'd1,
      CSR_LINE_COUNT  = 2'd2
   } grd_csr_type;

   typedef struct packed {
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
      logic run_last;
      logic grid_done;
   } grd_flags_type;

endpackage

FILE: rtl/grd_if.sv
// Valid/ready channel interfaces for sample input and field results.
// Depends on grd_pkg.
interface grd_req_if #(
   parameter int SAMPLE_BITS = grd_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] potential;

   modport source (output valid, output potential, input ready);
   modport sink   (input valid, input potential, output ready);
endinterface

interface grd_rsp_if #(
   parameter int ROW_W = $clog2(grd_pkg::MAX_LINES_DEF),
   parameter int COL_W = $clog2(grd_pkg::LINE_LEN_DEF)
);
   import grd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] field_x;
   logic signed [FIELD_W-1:0] field_y;
   logic [ROW_W-1:0]          line_index;
   logic [COL_W-1:0]          column_index;
   logic                      run_last;
   logic                      grid_done;

   modport source (output valid, output field_x, output field_y, output line_index,
                   output column_index, output run_last, output grid_done, input ready);
   modport sink   (input valid, input field_x, input field_y, input line_index,
                   input column_index, input run_last, input grid_done, output ready);
endinterface

FILE: rtl/grd_store.sv
// Three-line sample store: one write port, two registered read ports.
// Depends on grd_pkg.
module grd_store #(
   parameter int SAMPLE_BITS = grd_pkg::SAMPLE_BITS_DEF,
   parameter int LINE_LEN    = grd_pkg::LINE_LEN_DEF
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [$clog2(grd_pkg::SLOT_COUNT*LINE_LEN)-1:0] wr_addr,
   input  logic signed [SAMPLE_BITS-1:0]                   wr_data,
   input  logic                                            rd_en,
   input  logic [$clog2(grd_pkg::SLOT_COUNT*LINE_LEN)-1:0] rd_addr_a,
   input  logic [$clog2(grd_pkg::SLOT_COUNT*LINE_LEN)-1:0] rd_addr_b,
   output logic signed [SAMPLE_BITS-1:0]                   rd_data_a,
   output logic signed [SAMPLE_BITS-1:0]                   rd_data_b
);
   import grd_pkg::*;

   localparam int DEPTH = SLOT_COUNT * LINE_LEN;

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_a_ff;
   logic signed [SAMPLE_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/grd_scale.sv
// Scaled difference (a - b) * inv_spacing >> 12 or 13, saturated to 32 bits.
// Depends on grd_pkg.
module grd_scale #(
   parameter int SAMPLE_BITS = grd_pkg::SAMPLE_BITS_DEF
) (
   input  logic signed [SAMPLE_BITS-1:0]      minuend,
   input  logic signed [SAMPLE_BITS-1:0]      subtrahend,
   input  logic                               half,
   input  logic [grd_pkg::INV_W-1:0]          inv_spacing,
   output logic signed [grd_pkg::FIELD_W-1:0] result
);
   import grd_pkg::*;

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int PROD_W = DIFF_W + INV_W + 1;

   logic signed [DIFF_W-1:0] diff;
   logic signed [INV_W:0]    inv_s;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] shifted;

   assign diff    = DIFF_W'(minuend) - DIFF_W'(subtrahend);
   assign inv_s   = {1'b0, inv_spacing};
   assign prod    = diff * inv_s;
   assign shifted = half ? (prod >>> SHIFT_HALF) : (prod >>> SHIFT_ONE);

   generate
      if (PROD_W > FIELD_W) begin : g_sat
         logic sat_hi;
         logic sat_lo;
         assign sat_hi = !shifted[PROD_W-1] && (|shifted[PROD_W-2:FIELD_W-1]);
         assign sat_lo = shifted[PROD_W-1] && !(&shifted[PROD_W-2:FIELD_W-1]);
         always_comb begin
            if (sat_hi) begin
               result = {1'b0, {(FIELD_W-1){1'b1}}};
            end else if (sat_lo) begin
               result = {1'b1, {(FIELD_W-1){1'b0}}};
            end else begin
               result = shifted[FIELD_W-1:0];
            end
         end
      end else begin : g_ext
         assign result = FIELD_W'(shifted);
      end
   endgenerate

endmodule

FILE: rtl/grd_seq.sv
// Grid position counters, final-line flush sequencer and store addressing.
// Depends on grd_pkg.
module grd_seq #(
   parameter int LINE_LEN  = grd_pkg::LINE_LEN_DEF,
   parameter int MAX_LINES = grd_pkg::MAX_LINES_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            restart,
   input  logic                                            in_fire,
   input  logic                                            load_ok,
   input  logic [$clog2(LINE_LEN+1)-1:0]                   eff_w,
   input  logic [$clog2(MAX_LINES+1)-1:0]                  eff_l,
   output logic                                            flushing,
   output logic                                            emit,
   output logic                                            in_col_zero,
   output logic [$clog2(MAX_LINES)-1:0]                    row,
   output logic [$clog2(LINE_LEN)-1:0]                     col,
   output grd_pkg::grd_flags_type                          flags,
   output logic [$clog2(grd_pkg::SLOT_COUNT*LINE_LEN)-1:0] wr_addr,
   output logic [$clog2(grd_pkg::SLOT_COUNT*LINE_LEN)-1:0] rd_addr_a,
   output logic [$clog2(grd_pkg::SLOT_COUNT*LINE_LEN)-1:0] rd_addr_b
);
   import grd_pkg::*;

   localparam int COL_W   = $clog2(LINE_LEN);
   localparam int ROW_W   = $clog2(MAX_LINES);
   localparam int LEN_W   = $clog2(LINE_LEN+1);
   localparam int LINES_W = $clog2(MAX_LINES+1);
   localparam int ADDR_W  = $clog2(SLOT_COUNT*LINE_LEN);

   logic [COL_W-1:0]   col_ff, col_in, fcol_ff, fcol_in;
   logic [ROW_W-1:0]   line_ff, line_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in, fslot_ff, fslot_in;
   logic               flush_ff, flush_in;
   logic [LEN_W-1:0]   last_col;
   logic [LINES_W-1:0] last_row;
   logic               in_last_col, in_last_row, f_last_col;

   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(SLOT_COUNT-1) : s - SLOT_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                 input logic [COL_W-1:0]  c);
      return ADDR_W'(s) * ADDR_W'(LINE_LEN) + ADDR_W'(c);
   endfunction

   function automatic logic [COL_W-1:0] col_step(input logic [COL_W-1:0] c);
      return (c == COL_W'(LINE_LEN-1)) ? c : c + COL_W'(1);
   endfunction

   assign last_col    = eff_w - LEN_W'(1);
   assign last_row    = eff_l - LINES_W'(1);
   assign in_last_col = (LEN_W'(col_ff) == last_col);
   assign in_last_row = (LINES_W'(line_ff) == last_row);
   assign f_last_col  = (LEN_W'(fcol_ff) == last_col);

   always_comb begin
      col_in   = col_ff;
      line_in  = line_ff;
      slot_in  = slot_ff;
      fcol_in  = fcol_ff;
      fslot_in = fslot_ff;
      flush_in = flush_ff;
      if (restart) begin
         col_in   = '0;
         line_in  = '0;
         slot_in  = '0;
         flush_in = 1'b0;
      end else if (in_fire) begin
         if (in_last_row && in_last_col) begin
            col_in   = '0;
            line_in  = '0;
            slot_in  = '0;
            flush_in = 1'b1;
            fcol_in  = '0;
            fslot_in = slot_ff;
         end else if (in_last_col) begin
            col_in  = '0;
            line_in = line_ff + ROW_W'(1);
            slot_in = (slot_ff == SLOT_W'(SLOT_COUNT-1)) ? '0 : slot_ff + SLOT_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end else if (flush_ff && load_ok) begin
         if (f_last_col) begin
            flush_in = 1'b0;
         end else begin
            fcol_in = fcol_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      emit    = (in_fire && (line_ff != '0)) || (flush_ff && load_ok);
      wr_addr = addr_of(slot_ff, col_ff);
      if (flush_ff) begin
         row             = ROW_W'(last_row);
         col             = fcol_ff;
         flags.first_row = 1'b0;
         flags.last_row  = 1'b1;
         flags.first_col = (fcol_ff == '0);
         flags.last_col  = f_last_col;
         flags.run_last  = f_last_col;
         flags.grid_done = f_last_col;
         rd_addr_a       = addr_of(slot_back(fslot_ff), fcol_ff);
         rd_addr_b       = addr_of(fslot_ff, col_step(fcol_ff));
      end else begin
         row             = line_ff - ROW_W'(1);
         col             = col_ff;
         flags.first_row = (line_ff == ROW_W'(1));
         flags.last_row  = 1'b0;
         flags.first_col = (col_ff == '0);
         flags.last_col  = in_last_col;
         flags.run_last  = !(in_last_row && in_last_col);
         flags.grid_done = 1'b0;
         rd_addr_a       = addr_of(slot_back(slot_back(slot_ff)), col_ff);
         rd_addr_b       = addr_of(slot_back(slot_ff), col_step(col_ff));
      end
   end

   assign flushing    = flush_ff;
   assign in_col_zero = (col_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         line_ff  <= '0;
         slot_ff  <= '0;
         fcol_ff  <= '0;
         fslot_ff <= '0;
         flush_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         line_ff  <= line_in;
         slot_ff  <= slot_in;
         fcol_ff  <= fcol_in;
         fslot_ff <= fslot_in;
         flush_ff <= flush_in;
      end
   end

endmodule

FILE: rtl/grid_potential_gradient.sv
// Top level of the grid potential gradient block: CSRs, operand stage, result register.
// Depends on grd_pkg, grd_if, grd_store, grd_scale and grd_seq.
//
// Takes one potential sample per clock while not stalled and returns E = -grad(phi)
// for the node one line above it through the operand register, then the result
// register. Samples on line 0 produce no result. After the last sample of the grid
// the input is held off while the final line is read back from the three-line
// store, one node per cycle unless the operand stage stalls, through its two read ports.
// A write to line_length or line_count restarts the grid at line 0, column 0; the
// store is not cleared and needs no pass after reset. Out-of-range geometry is
// clamped to 3..LINE_LEN and 3..MAX_LINES.
module grid_potential_gradient #(
   parameter int LINE_LEN    = grd_pkg::LINE_LEN_DEF,
   parameter int MAX_LINES   = grd_pkg::MAX_LINES_DEF,
   parameter int SAMPLE_BITS = grd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   grd_req_if.sink                          req_ch,
   grd_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [grd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [grd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import grd_pkg::*;

   localparam int COL_W   = $clog2(LINE_LEN);
   localparam int ROW_W   = $clog2(MAX_LINES);
   localparam int LEN_W   = $clog2(LINE_LEN+1);
   localparam int LINES_W = $clog2(MAX_LINES+1);
   localparam int ADDR_W  = $clog2(SLOT_COUNT*LINE_LEN);

   logic [INV_W-1:0]     inv_ff, inv_in;
   logic [LEN_REG_W-1:0] len_ff, len_in;
   logic [CNT_REG_W-1:0] cnt_ff, cnt_in;
   logic                 restart;
   logic [LEN_W-1:0]     eff_w;
   logic [LINES_W-1:0]   eff_l;

   logic                 flushing, emit, in_col_zero, in_fire, load_ok;
   logic [ROW_W-1:0]     seq_row;
   logic [COL_W-1:0]     seq_col;
   grd_flags_type        seq_flags;
   logic [ADDR_W-1:0]    wr_addr, rd_addr_a, rd_addr_b;
   logic signed [SAMPLE_BITS-1:0] rd_a, rd_b;

   logic signed [SAMPLE_BITS-1:0] head0_ff, head0_in;
   logic                          s1_vld_ff, s1_vld_in, s1_go;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic signed [SAMPLE_BITS-1:0] s1_left_ff, s1_left_in;
   logic signed [SAMPLE_BITS-1:0] s1_center_ff, s1_center_in;
   logic [ROW_W-1:0]              s1_row_ff, s1_row_in;
   logic [COL_W-1:0]              s1_col_ff, s1_col_in;
   grd_flags_type                 s1_flags_ff, s1_flags_in;

   logic signed [SAMPLE_BITS-1:0] fx_a, fx_b, fy_a, fy_b;
   logic                          fx_half, fy_half;
   logic signed [FIELD_W-1:0]     fx, fy;

   logic                      out_vld_ff, out_vld_in;
   logic signed [FIELD_W-1:0] out_fx_ff, out_fy_ff;
   logic [ROW_W-1:0]          out_row_ff;
   logic [COL_W-1:0]          out_col_ff;
   logic                      out_run_last_ff, out_done_ff;

   // configuration registers
   always_comb begin
      inv_in  = inv_ff;
      len_in  = len_ff;
      cnt_in  = cnt_ff;
      restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_INV_SPACING: begin
               inv_in = csr_wdata[INV_W-1:0];
            end
            CSR_LINE_LENGTH: begin
               len_in  = csr_wdata[LEN_REG_W-1:0];
               restart = 1'b1;
            end
            CSR_LINE_COUNT: begin
               cnt_in  = csr_wdata[CNT_REG_W-1:0];
               restart = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (int'(len_ff) < MIN_DIM) begin
         eff_w = LEN_W'(MIN_DIM);
      end else if (int'(len_ff) > LINE_LEN) begin
         eff_w = LEN_W'(LINE_LEN);
      end else begin
         eff_w = LEN_W'(len_ff);
      end
      if (int'(cnt_ff) < MIN_DIM) begin
         eff_l = LINES_W'(MIN_DIM);
      end else if (int'(cnt_ff) > MAX_LINES) begin
         eff_l = LINES_W'(MAX_LINES);
      end else begin
         eff_l = LINES_W'(cnt_ff);
      end
   end

   // handshake
   assign s1_go        = s1_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign load_ok      = !s1_vld_ff || s1_go;
   assign req_ch.ready = !flushing && load_ok;
   assign in_fire      = req_ch.valid && req_ch.ready;

   grd_seq #(
      .LINE_LEN  (LINE_LEN),
      .MAX_LINES (MAX_LINES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .in_fire     (in_fire),
      .load_ok     (load_ok),
      .eff_w       (eff_w),
      .eff_l       (eff_l),
      .flushing    (flushing),
      .emit        (emit),
      .in_col_zero (in_col_zero),
      .row         (seq_row),
      .col         (seq_col),
      .flags       (seq_flags),
      .wr_addr     (wr_addr),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b)
   );

   grd_store #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LINE_LEN    (LINE_LEN)
   ) u_store (
      .clock     (clock),
      .wr_en     (in_fire),
      .wr_addr   (wr_addr),
      .wr_data   (req_ch.potential),
      .rd_en     (emit),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // operand stage; left/center slide along the line, column 0 comes from head0
   always_comb begin
      head0_in     = (in_fire && in_col_zero) ? req_ch.potential : head0_ff;
      s1_vld_in    = emit ? 1'b1 : (s1_go ? 1'b0 : s1_vld_ff);
      s1_sample_in = s1_sample_ff;
      s1_left_in   = s1_left_ff;
      s1_center_in = s1_center_ff;
      s1_row_in    = s1_row_ff;
      s1_col_in    = s1_col_ff;
      s1_flags_in  = s1_flags_ff;
      if (emit) begin
         s1_sample_in = req_ch.potential;
         s1_row_in    = seq_row;
         s1_col_in    = seq_col;
         s1_flags_in  = seq_flags;
         if (seq_flags.first_col) begin
            s1_center_in = head0_ff;
         end else begin
            s1_left_in   = s1_center_ff;
            s1_center_in = rd_b;
         end
      end
   end

   always_comb begin
      fx_a    = s1_flags_ff.first_row ? s1_center_ff : rd_a;
      fx_b    = s1_flags_ff.last_row ? s1_center_ff : s1_sample_ff;
      fx_half = !(s1_flags_ff.first_row || s1_flags_ff.last_row);
      fy_a    = s1_flags_ff.first_col ? s1_center_ff : s1_left_ff;
      fy_b    = s1_flags_ff.last_col ? s1_center_ff : rd_b;
      fy_half = !(s1_flags_ff.first_col || s1_flags_ff.last_col);
   end

   grd_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale_x (
      .minuend     (fx_a),
      .subtrahend  (fx_b),
      .half        (fx_half),
      .inv_spacing (inv_ff),
      .result      (fx)
   );

   grd_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale_y (
      .minuend     (fy_a),
      .subtrahend  (fy_b),
      .half        (fy_half),
      .inv_spacing (inv_ff),
      .result      (fy)
   );

   assign out_vld_in = s1_go ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff     <= INV_SPACING_RST;
         len_ff     <= LINE_LENGTH_RST;
         cnt_ff     <= LINE_COUNT_RST;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         inv_ff     <= inv_in;
         len_ff     <= len_in;
         cnt_ff     <= cnt_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head0_ff     <= head0_in;
      s1_sample_ff <= s1_sample_in;
      s1_left_ff   <= s1_left_in;
      s1_center_ff <= s1_center_in;
      s1_row_ff    <= s1_row_in;
      s1_col_ff    <= s1_col_in;
      s1_flags_ff  <= s1_flags_in;
      if (s1_go) begin
         out_fx_ff       <= fx;
         out_fy_ff       <= fy;
         out_row_ff      <= s1_row_ff;
         out_col_ff      <= s1_col_ff;
         out_run_last_ff <= s1_flags_ff.run_last;
         out_done_ff     <= s1_flags_ff.grid_done;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.field_x      = out_fx_ff;
   assign rsp_ch.field_y      = out_fy_ff;
   assign rsp_ch.line_index   = out_row_ff;
   assign rsp_ch.column_index = out_col_ff;
   assign rsp_ch.run_last     = out_run_last_ff;
   assign rsp_ch.grid_done    = out_done_ff;

endmodule

FILE: rtl/grd_check.sv
// Port-level checks on the result channel of grid_potential_gradient, bound to it.
// Depends on grd_pkg and grid_potential_gradient.
module grd_check #(
   parameter int LINE_LEN  = grd_pkg::LINE_LEN_DEF,
   parameter int MAX_LINES = grd_pkg::MAX_LINES_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [grd_pkg::FIELD_W-1:0] rsp_field_x,
   input logic signed [grd_pkg::FIELD_W-1:0] rsp_field_y,
   input logic [$clog2(MAX_LINES)-1:0]       rsp_line_index,
   input logic [$clog2(LINE_LEN)-1:0]        rsp_column_index,
   input logic                               rsp_run_last,
   input logic                               rsp_grid_done
);
   import grd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_x) &&
      $stable(rsp_field_y) && $stable(rsp_line_index) && $stable(rsp_column_index) &&
      $stable(rsp_run_last) && $stable(rsp_grid_done))
      else $error("result changed while stalled");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_done |-> rsp_run_last)
      else $error("grid end not marked as end of run");

   a_done_not_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_done |-> rsp_line_index != '0 && rsp_column_index != '0)
      else $error("grid end reported on first line or column");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind grid_potential_gradient grd_check #(
   .LINE_LEN  (LINE_LEN),
   .MAX_LINES (MAX_LINES)
) u_grd_check (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_field_x      (rsp_ch.field_x),
   .rsp_field_y      (rsp_ch.field_y),
   .rsp_line_index   (rsp_ch.line_index),
   .rsp_column_index (rsp_ch.column_index),
   .rsp_run_last     (rsp_ch.run_last),
   .rsp_grid_done    (rsp_ch.grid_done)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_potential_gradient: streams potential grids through
// req_ch, predicts every field result in-bench and checks each rsp_ch transfer in order.
// Depends on grd_pkg, grd_if and the RTL of the block.
module testbench;
   import grd_pkg::*;

   localparam int LEN_MAX       = LINE_LEN_DEF;
   localparam int LINES_MAX     = MAX_LINES_DEF;
   localparam int SB            = SAMPLE_BITS_DEF;
   localparam int ROW_W         = $clog2(MAX_LINES_DEF);
   localparam int COL_W         = $clog2(LINE_LEN_DEF);
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 150;
   localparam int RANDOM_ITEMS  = 40;
   localparam int MAX_REPORTS   = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [SB-1:0] PHI_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] PHI_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam longint FIELD_HI = (longint'(1) <<< (FIELD_W-1)) - 1;
   localparam longint FIELD_LO = -(longint'(1) <<< (FIELD_W-1));

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] field_x;
      logic signed [FIELD_W-1:0] field_y;
      logic [ROW_W-1:0]          line_index;
      logic [COL_W-1:0]          column_index;
      logic                      run_last;
      logic                      grid_done;
   } node_field_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   grd_req_if req_ch ();
   grd_rsp_if rsp_ch ();

   grid_potential_gradient u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of registers, line store and position
   logic [INV_W-1:0]     spacing_q = INV_SPACING_RST;
   logic [LEN_REG_W-1:0] len_q     = LINE_LENGTH_RST;
   logic [CNT_REG_W-1:0] count_q   = LINE_COUNT_RST;
   logic signed [SB-1:0] phi_store [SLOT_COUNT*LEN_MAX];
   int                   next_col  = 0;
   int                   next_line = 0;

   node_field_type fields_due[$];
   int             mismatches  = 0;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   int             gap_max     = 0;
   bit             hold_req    = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int eff_len();
      if (len_q < MIN_DIM) return MIN_DIM;
      if (len_q > LEN_MAX) return LEN_MAX;
      return int'(len_q);
   endfunction

   function automatic int eff_lines();
      if (count_q < MIN_DIM) return MIN_DIM;
      if (count_q > LINES_MAX) return LINES_MAX;
      return int'(count_q);
   endfunction

   function automatic logic signed [FIELD_W-1:0] scaled_diff(input logic signed [SB-1:0] a,
                                                             input logic signed [SB-1:0] b,
                                                             input int sh);
      longint p;
      p = (longint'(a) - longint'(b)) * longint'(spacing_q);
      p = p >>> sh;
      if (p > FIELD_HI) p = FIELD_HI;
      if (p < FIELD_LO) p = FIELD_LO;
      return p[FIELD_W-1:0];
   endfunction

   function automatic logic signed [SB-1:0] phi_at(input int r, input int c);
      return phi_store[(r % SLOT_COUNT)*LEN_MAX + c];
   endfunction

   function automatic node_field_type node_field(input int r, input int c, input int w,
                                                 input int l, input bit done);
      node_field_type f;
      if (r == 0) begin
         f.field_x = scaled_diff(phi_at(0, c), phi_at(1, c), SHIFT_ONE);
      end else if (r == l-1) begin
         f.field_x = scaled_diff(phi_at(l-2, c), phi_at(l-1, c), SHIFT_ONE);
      end else begin
         f.field_x = scaled_diff(phi_at(r-1, c), phi_at(r+1, c), SHIFT_HALF);
      end
      if (c == 0) begin
         f.field_y = scaled_diff(phi_at(r, 0), phi_at(r, 1), SHIFT_ONE);
      end else if (c == w-1) begin
         f.field_y = scaled_diff(phi_at(r, w-2), phi_at(r, w-1), SHIFT_ONE);
      end else begin
         f.field_y = scaled_diff(phi_at(r, c-1), phi_at(r, c+1), SHIFT_HALF);
      end
      f.line_index   = ROW_W'(r);
      f.column_index = COL_W'(c);
      f.run_last     = 1'b0;
      f.grid_done    = done;
      return f;
   endfunction

   // store the sample, queue the fields it releases, advance the position
   task automatic predict_field(input logic signed [SB-1:0] phi);
      node_field_type caused[$];
      int             w, l, r, c;
      bit             at_end;
      w = eff_len();
      l = eff_lines();
      if (next_col >= w) next_col = 0;
      if (next_line >= l) next_line = 0;
      r = next_line;
      c = next_col;
      phi_store[(r % SLOT_COUNT)*LEN_MAX + c] = phi;
      at_end = (r == l-1) && (c == w-1);
      if (r >= 1) caused.push_back(node_field(r-1, c, w, l, 1'b0));
      if (at_end) begin
         for (int k = 0; k < w; k++) caused.push_back(node_field(l-1, k, w, l, k == w-1));
      end
      if (caused.size() > 0) caused[caused.size()-1].run_last = 1'b1;
      foreach (caused[j]) fields_due.push_back(caused[j]);
      if (at_end) begin
         next_col  = 0;
         next_line = 0;
      end else if (c + 1 >= w) begin
         next_col  = 0;
         next_line = r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_INV_SPACING: spacing_q = val[INV_W-1:0];
         CSR_LINE_LENGTH: begin
            len_q     = val[LEN_REG_W-1:0];
            next_col  = 0;
            next_line = 0;
         end
         CSR_LINE_COUNT: begin
            count_q   = val[CNT_REG_W-1:0];
            next_col  = 0;
            next_line = 0;
         end
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] inv,
                               input logic [CSR_DATA_W-1:0] len,
                               input logic [CSR_DATA_W-1:0] cnt);
      write_reg(CSR_INV_SPACING, inv);
      write_reg(CSR_LINE_LENGTH, len);
      write_reg(CSR_LINE_COUNT, cnt);
   endtask

   // valid stays high across a burst; gaps only open between bursts
   task automatic send_potential(input logic signed [SB-1:0] phi);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid     <= 1'b1;
      req_ch.potential <= phi;
      do @(posedge clock); while (!req_ch.ready);
      predict_field(phi);
      burst_left--;
   endtask

   function automatic logic signed [SB-1:0] pick_potential();
      int near_zero;
      near_zero = int'($urandom_range(0, 127)) - 64;
      case ($urandom_range(0, 7))
         0:       return PHI_MAX;
         1:       return PHI_MIN;
         2, 3:    return near_zero[SB-1:0];
         default: return SB'($urandom);
      endcase
   endfunction

   task automatic send_grid(input int count);
      repeat (count) send_potential(pick_potential());
   endtask

   task automatic drain_fields();
      req_ch.valid <= 1'b0;
      while (fields_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_values();
      gap_max = 4;
      send_grid(LEN_MAX + 6);
      drain_fields();
   endtask

   task automatic test_corner_grids();
      logic signed [SB-1:0] ones [9];
      ones = '{-1, 0, 1, 0, -1, 0, 1, 1, -1};
      gap_max = 0;
      set_geometry(16'hFFFF, 16'd3, 16'd3);
      for (int k = 0; k < 9; k++) send_potential((k % 2 == 0) ? PHI_MAX : PHI_MIN);
      foreach (ones[k]) send_potential(ones[k]);
      drain_fields();
      // unknown index between two halves of a grid must not disturb it
      send_potential(PHI_MIN);
      send_potential(PHI_MAX);
      send_potential(PHI_MAX);
      send_potential(PHI_MIN);
      drain_fields();
      write_reg(CSR_UNUSED, 16'hFFFF);
      write_reg(CSR_INV_SPACING, 16'd0);
      repeat (5) send_potential(PHI_MAX);
      drain_fields();
   endtask

   task automatic test_clamped_geometry();
      gap_max = 3;
      set_geometry(16'd4096, 16'd0, 16'd0);
      send_grid(MIN_DIM*MIN_DIM);
      drain_fields();
      set_geometry(16'($urandom_range(0, 65535)), 16'hFFFF, 16'hF803);
      send_grid(LEN_MAX + 4);
      drain_fields();
      gap_max = 2;
      set_geometry(16'd2048, 16'h0043, 16'd2047);
      send_grid(4*MIN_DIM);
      drain_fields();
   endtask

   task automatic test_restart();
      gap_max = 5;
      set_geometry(16'($urandom_range(0, 65535)), 16'd5, 16'd4);
      send_grid(12);
      drain_fields();
      write_reg(CSR_LINE_LENGTH, 16'd5);
      send_grid(7);
      drain_fields();
      write_reg(CSR_INV_SPACING, 16'($urandom_range(0, 65535)));
      send_grid(13);
      drain_fields();
      write_reg(CSR_LINE_COUNT, 16'd4);
      send_grid(20);
      drain_fields();
   endtask

   task automatic test_backpressure();
      gap_max = 0;
      set_geometry(16'd6000, 16'd8, 16'd3);
      hold_req = 1'b1;
      send_grid(24);
      drain_fields();
   endtask

   task automatic test_random_grids();
      int                    sent, w, l, n;
      logic [CSR_DATA_W-1:0] inv;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 5) == 0) ? LEN_MAX : $urandom_range(MIN_DIM, 8);
         l = $urandom_range(MIN_DIM, 6);
         case ($urandom_range(0, 5))
            0:       inv = '0;
            1:       inv = '1;
            2:       inv = INV_SPACING_RST;
            default: inv = 16'($urandom_range(0, 65535));
         endcase
         set_geometry(inv, 16'(w), 16'(l));
         gap_max = 3*$urandom_range(0, 3);
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w*l) : w*l*$urandom_range(1, 2);
         if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
         send_grid(n);
         sent += n;
         drain_fields();
      end
   endtask

   // receiver: stall pattern in random phases, plus one long hold on request
   initial begin
      rx_mode_type mode;
      int          phase_left, tick, hold_left;
      phase_left = 0;
      tick = 0;
      hold_left = 0;
      mode = RX_OPEN;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            if (phase_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               phase_left = $urandom_range(8, 80);
            end
            phase_left--;
            tick++;
            case (mode)
               RX_OPEN:   rsp_ch.ready <= 1'b1;
               RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ch.ready <= (tick % 4 == 0);
               default:   rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      node_field_type got, want;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.field_x, rsp_ch.field_y, rsp_ch.line_index, rsp_ch.column_index,
                   rsp_ch.run_last, rsp_ch.grid_done};
            if (fields_due.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("unexpected field transfer: line=%0d col=%0d fx=%0d fy=%0d",
                           got.line_index, got.column_index, got.field_x, got.field_y);
               mismatches++;
            end else begin
               want = fields_due.pop_front();
               if (got !== want) begin
                  if (mismatches < MAX_REPORTS) begin
                     $display("mismatch exp: fx=%0d fy=%0d line=%0d col=%0d last=%0b done=%0b",
                              want.field_x, want.field_y, want.line_index, want.column_index,
                              want.run_last, want.grid_done);
                     $display("         got: fx=%0d fy=%0d line=%0d col=%0d last=%0b done=%0b",
                              got.field_x, got.field_y, got.line_index, got.column_index,
                              got.run_last, got.grid_done);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[grid_potential_gradient] ERROR");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.potential <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_corner_grids();
      test_clamped_geometry();
      test_restart();
      test_backpressure();
      test_random_grids();
      if (mismatches == 0 && fields_due.size() == 0) begin
         $display("[grid_potential_gradient] OK");
      end else begin
         $display("[grid_potential_gradient] ERROR");
      end
      $finish;
   end

endmodule
